// ----- design/bci_pkg.sv -----
// bci_pkg: types, constants and clip helpers for the bicubic interpolator
// depends on: nothing
package bci_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int ROW_BITS    = SAMPLE_BITS + 2;
  localparam int ACC_BITS    = ROW_BITS + 3 * FRAC_BITS + 5;
  localparam int RND_SHIFT   = 3 * FRAC_BITS + 1;

  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [FRAC_BITS-1:0]          frac_t;
  typedef logic signed [ROW_BITS-1:0]    row_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic [1:0]                    row_idx_t;
  typedef logic [QPTR_BITS-1:0]          qptr_t;
  typedef logic [QPTR_BITS:0]            qcnt_t;

  localparam row_idx_t LAST_ROW   = 2'd3;
  localparam qcnt_t    QFULL      = qcnt_t'(QDEPTH);
  localparam qptr_t    QPTR_LAST  = qptr_t'(QDEPTH - 1);
  localparam acc_t     RND_HALF   = acc_t'(1) <<< (3 * FRAC_BITS);
  localparam acc_t     ROW_MAX    = (acc_t'(1) <<< (ROW_BITS - 1)) - acc_t'(1);
  localparam acc_t     ROW_MIN    = ~ROW_MAX;
  localparam acc_t     SAMPLE_MAX = (acc_t'(1) <<< (SAMPLE_BITS - 1)) - acc_t'(1);
  localparam acc_t     SAMPLE_MIN = ~SAMPLE_MAX;

  // one queued row transaction, classified by the front end
  typedef struct packed {
    sample_t [3:0] smp;
    frac_t         fy;
    frac_t         fx;
    row_idx_t      idx;
    logic          last;
  } ent_t;

  typedef struct packed {
    logic valid;
    ent_t ent;
  } bci_q_t;

  typedef struct packed {
    logic       start;
    row_t [3:0] p;
    frac_t      f;
  } cu_req_t;

  typedef struct packed {
    logic done;
    acc_t res;
  } cu_rsp_t;

  typedef struct packed {
    sample_t v;
    logic    hit;
  } sat_t;

  function automatic row_t clip_row(acc_t v);
    row_t r;
    if (v > ROW_MAX) begin
      r = ROW_MAX[ROW_BITS-1:0];
    end else if (v < ROW_MIN) begin
      r = ROW_MIN[ROW_BITS-1:0];
    end else begin
      r = v[ROW_BITS-1:0];
    end
    return r;
  endfunction

  function automatic sat_t clip_smp(acc_t v);
    sat_t r;
    if (v > SAMPLE_MAX) begin
      r.v   = SAMPLE_MAX[SAMPLE_BITS-1:0];
      r.hit = 1'b1;
    end else if (v < SAMPLE_MIN) begin
      r.v   = SAMPLE_MIN[SAMPLE_BITS-1:0];
      r.hit = 1'b1;
    end else begin
      r.v   = v[SAMPLE_BITS-1:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- design/bci_if.sv -----
// bci_if: valid/ready channel interfaces for row input and result output
// depends on: bci_pkg
interface bci_in_if;
  import bci_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_0;
  sample_t sample_1;
  sample_t sample_2;
  sample_t sample_3;
  frac_t   frac_y;
  frac_t   frac_x;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3, frac_y, frac_x,
                  input ready);
  modport sink (input valid, sample_0, sample_1, sample_2, sample_3, frac_y, frac_x,
                output ready);
endinterface

interface bci_out_if;
  import bci_pkg::*;
  logic    valid;
  logic    ready;
  sample_t value;
  logic    saturated;

  modport source (output valid, value, saturated, input ready);
  modport sink (input valid, value, saturated, output ready);
endinterface

// ----- design/bci_cubic.sv -----
// bci_cubic: iterative catmull-rom cubic, horner form on one shared multiplier
// depends on: bci_pkg
module bci_cubic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bci_pkg::cu_req_t  req_i,
  output bci_pkg::cu_rsp_t  rsp_o
);
  import bci_pkg::*;

  typedef enum logic [5:0] {
    CU_IDLE = 6'b000001,
    CU_COEF = 6'b000010,
    CU_H1   = 6'b000100,
    CU_H2   = 6'b001000,
    CU_H3   = 6'b010000,
    CU_RND  = 6'b100000
  } cu_state_e;

  cu_state_e state_q, state_d;

  row_t  p_q [4];
  frac_t f_q;
  acc_t  c_q, a_q, b_q, acc_q;
  acc_t  e0, e1, e2, e3, d12;
  acc_t  mul_op, add_op, prod, acc_d, rnd;
  logic signed [FRAC_BITS:0] fs;

  assign e0  = acc_t'(p_q[0]);
  assign e1  = acc_t'(p_q[1]);
  assign e2  = acc_t'(p_q[2]);
  assign e3  = acc_t'(p_q[3]);
  assign d12 = e1 - e2;
  assign fs  = signed'({1'b0, f_q});

  always_comb begin
    case (state_q)
      CU_H1: begin
        mul_op = b_q;
        add_op = a_q <<< FRAC_BITS;
      end
      CU_H2: begin
        mul_op = acc_q;
        add_op = c_q <<< (2 * FRAC_BITS);
      end
      default: begin
        mul_op = acc_q;
        add_op = '0;
      end
    endcase
  end

  assign prod  = acc_t'(mul_op * fs);
  assign acc_d = prod + add_op;
  assign rnd   = (acc_q + RND_HALF) >>> RND_SHIFT;

  assign rsp_o.done = (state_q == CU_RND);
  assign rsp_o.res  = e1 + rnd;

  always_comb begin
    case (state_q)
      CU_IDLE: state_d = req_i.start ? CU_COEF : CU_IDLE;
      CU_COEF: state_d = CU_H1;
      CU_H1:   state_d = CU_H2;
      CU_H2:   state_d = CU_H3;
      CU_H3:   state_d = CU_RND;
      CU_RND:  state_d = CU_IDLE;
      default: state_d = CU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CU_IDLE && req_i.start) begin
      for (int i = 0; i < 4; i++) begin
        p_q[i] <= signed'(req_i.p[i]);
      end
      f_q <= req_i.f;
    end
    if (state_q == CU_COEF) begin
      c_q <= e2 - e0;
      a_q <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
      b_q <= ((d12 <<< 1) + d12) + e3 - e0;
    end
    if (state_q == CU_H1 || state_q == CU_H2 || state_q == CU_H3) begin
      acc_q <= acc_d;
    end
  end

endmodule

// ----- design/bci_front.sv -----
// bci_front: accepts row transactions, tags row position, buffers them in a short queue
// depends on: bci_pkg, bci_if
module bci_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  bci_in_if.sink          in_i,
  output bci_pkg::bci_q_t q_o,
  input  logic            pop_i
);
  import bci_pkg::*;

  ent_t     ent_q [QDEPTH];
  qptr_t    wr_ptr_q, rd_ptr_q;
  qcnt_t    cnt_q;
  row_idx_t row_count_q;
  logic     push;
  ent_t     ent_new;

  assign in_i.ready = (cnt_q != QFULL);
  assign push       = in_i.valid && in_i.ready;

  assign q_o.valid = (cnt_q != '0);
  assign q_o.ent   = ent_q[rd_ptr_q];

  always_comb begin
    ent_new.smp  = {in_i.sample_3, in_i.sample_2, in_i.sample_1, in_i.sample_0};
    ent_new.fy   = in_i.frac_y;
    ent_new.fx   = in_i.frac_x;
    ent_new.idx  = row_count_q;
    ent_new.last = (row_count_q == LAST_ROW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      row_count_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q    <= (wr_ptr_q == QPTR_LAST) ? '0 : wr_ptr_q + qptr_t'(1);
        row_count_q <= row_count_q + row_idx_t'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_LAST) ? '0 : rd_ptr_q + qptr_t'(1);
      end
      case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + qcnt_t'(1);
        2'b01:   cnt_q <= cnt_q - qcnt_t'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= ent_new;
    end
  end

endmodule

// ----- design/bci_back.sv -----
// bci_back: sequences row and column passes on the cubic unit, holds row values and output
// depends on: bci_pkg, bci_if
module bci_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bci_pkg::bci_q_t  q_i,
  output logic             pop_o,
  output bci_pkg::cu_req_t req_o,
  input  bci_pkg::cu_rsp_t rsp_i,
  bci_out_if.source        out_o
);
  import bci_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_ROW  = 5'b00010,
    B_FST  = 5'b00100,
    B_FIN  = 5'b01000,
    B_HOLD = 5'b10000
  } back_state_e;

  back_state_e state_q, state_d;

  logic     last_q;
  row_idx_t idx_q;
  frac_t    fx_q;
  row_t     rows_q [3];
  row_t     row3_q;
  sat_t     fin_q;
  logic     ov_q;
  sat_t     ov_val_q;
  row_t     row_res;
  sat_t     fin_res;
  logic     out_free;

  assign row_res  = clip_row(rsp_i.res);
  assign fin_res  = clip_smp(rsp_i.res);
  assign out_free = !ov_q || out_o.ready;

  assign pop_o = (state_q == B_IDLE) && q_i.valid;

  always_comb begin
    req_o.start = 1'b0;
    req_o.f     = q_i.ent.fy;
    for (int i = 0; i < 4; i++) begin
      req_o.p[i] = row_t'(signed'(q_i.ent.smp[i]));
    end
    case (state_q)
      B_IDLE: begin
        req_o.start = q_i.valid;
      end
      B_FST: begin
        req_o.start = 1'b1;
        req_o.f     = fx_q;
        req_o.p     = {row3_q, rows_q[2], rows_q[1], rows_q[0]};
      end
      default: begin
        req_o.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (state_q)
      B_IDLE:  state_d = q_i.valid ? B_ROW : B_IDLE;
      B_ROW:   state_d = rsp_i.done ? (last_q ? B_FST : B_IDLE) : B_ROW;
      B_FST:   state_d = B_FIN;
      B_FIN:   state_d = rsp_i.done ? B_HOLD : B_FIN;
      B_HOLD:  state_d = out_free ? B_IDLE : B_HOLD;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_HOLD && out_free) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      last_q <= q_i.ent.last;
      idx_q  <= q_i.ent.idx;
      fx_q   <= q_i.ent.fx;
    end
    if (state_q == B_ROW && rsp_i.done) begin
      if (last_q) begin
        row3_q <= row_res;
      end else begin
        rows_q[idx_q] <= row_res;
      end
    end
    if (state_q == B_FIN && rsp_i.done) begin
      fin_q <= fin_res;
    end
    if (state_q == B_HOLD && out_free) begin
      ov_val_q <= fin_q;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.value     = ov_val_q.v;
  assign out_o.saturated = ov_val_q.hit;

endmodule

// ----- design/bicubic_interpolator_unit.sv -----
// bicubic_interpolator_unit: catmull-rom bicubic interpolator, top level
// depends on: bci_pkg, bci_if, bci_front, bci_cubic, bci_back
//
// Every four row transactions on in_i (four signed samples and frac_y each,
// frac_x taken from the fourth) yield one result on out_o: the rows are
// interpolated along y, then the four row values along x, rounded half up
// and saturated, with saturated set when the value was clipped. All passes
// share one cubic unit with a single multiplier, so a row transaction
// occupies the back end for a row pass and the fourth one for a row pass,
// a column pass and an output load. A two-entry queue lets in_i keep
// accepting while the back end is busy or a result is waiting on out_o.
module bicubic_interpolator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  bci_in_if.sink     in_i,
  bci_out_if.source  out_o
);
  import bci_pkg::*;

  bci_q_t  q;
  logic    pop;
  cu_req_t req;
  cu_rsp_t rsp;

  bci_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .q_o    (q),
    .pop_i  (pop)
  );

  bci_cubic u_cubic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  bci_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q),
    .pop_o  (pop),
    .req_o  (req),
    .rsp_i  (rsp),
    .out_o  (out_o)
  );

endmodule

// ----- tb/bicubic_interpolator_unit_test.sv -----
// bicubic_interpolator_unit_test: self-checking testbench for the bicubic interpolator
// drives row transactions with random gaps, predicts each 4x4 result and checks the output
// depends on: bci_pkg, bci_if, bicubic_interpolator_unit
`timescale 1ns / 100ps

module bicubic_interpolator_unit_test;
  import bci_pkg::*;

  localparam int          CLK_HALF    = 5;
  localparam int unsigned MAX_IDLE    = 18;
  localparam int unsigned HOLD_AT     = 80;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned SETTLE      = 64;
  localparam int unsigned RAND_GROUPS = 307;
  localparam sample_t     S_MAX       = 16'sh7fff;
  localparam sample_t     S_MIN       = 16'sh8000;
  localparam frac_t       F_FULL      = 8'hff;
  localparam frac_t       F_HALF      = 8'h80;

  typedef struct {
    sample_t     smp [4];
    frac_t       fy;
    frac_t       fx;
    int unsigned gap;
    bit          drain;
  } row_item_t;

  typedef struct packed {
    sample_t value;
    logic    saturated;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bci_in_if  rows_if ();
  bci_out_if pix_if ();

  bicubic_interpolator_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (rows_if),
    .out_o  (pix_if)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  row_item_t   row_q [$];
  pixel_t      pixel_q [$];
  int unsigned total_rows;
  int unsigned rows_sent;
  int unsigned results_seen;
  int unsigned faults;

  // predictor state
  logic [1:0] rows_held = 2'd0;
  longint     row_vals [3];

  // handshake bookkeeping
  bit          row_taken;
  bit          pix_taken;
  bit          staged;
  row_item_t   cur;
  int unsigned wait_left;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;

  function automatic longint catmull_rom(longint p [4], frac_t f);
    longint t, c, a, b, m;
    t = f;
    c = p[2] - p[0];
    a = 2 * p[0] - 5 * p[1] + 4 * p[2] - p[3];
    b = 3 * (p[1] - p[2]) + p[3] - p[0];
    m = t * ((c <<< (2 * FRAC_BITS)) + t * ((a <<< FRAC_BITS) + t * b));
    return p[1] + ((m + (longint'(1) <<< (3 * FRAC_BITS))) >>> (3 * FRAC_BITS + 1));
  endfunction

  function automatic longint clamp_to(longint v, int bits, output bit hit);
    longint hi, lo;
    hi  = (longint'(1) <<< (bits - 1)) - 1;
    lo  = -hi - 1;
    hit = 1'b0;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic void predict_pixel(sample_t s0, sample_t s1, sample_t s2, sample_t s3,
                                        frac_t fy, frac_t fx);
    longint p [4];
    longint row, v;
    bit     hit;
    pixel_t px;
    p[0] = s0;
    p[1] = s1;
    p[2] = s2;
    p[3] = s3;
    row  = clamp_to(catmull_rom(p, fy), ROW_BITS, hit);
    if (rows_held != 2'd3) begin
      row_vals[rows_held] = row;
      rows_held++;
    end else begin
      for (int i = 0; i < 3; i++) p[i] = row_vals[i];
      p[3]         = row;
      rows_held    = 2'd0;
      v            = clamp_to(catmull_rom(p, fx), SAMPLE_BITS, hit);
      px.value     = sample_t'(v);
      px.saturated = hit;
      pixel_q.push_back(px);
    end
  endfunction

  function automatic void add_row(sample_t s0, sample_t s1, sample_t s2, sample_t s3,
                                  frac_t fy, frac_t fx, int unsigned gap, bit drain);
    row_item_t r;
    r.smp[0] = s0;
    r.smp[1] = s1;
    r.smp[2] = s2;
    r.smp[3] = s3;
    r.fy     = fy;
    r.fx     = fx;
    r.gap    = gap;
    r.drain  = drain;
    row_q.push_back(r);
  endfunction

  function automatic sample_t pick_sample(int unsigned kind, int base);
    int v;
    case (kind)
      0: begin
        v = base + $signed($urandom_range(0, 511)) - 256;
        return sample_t'(v);
      end
      1: begin
        case ($urandom_range(0, 4))
          0: return S_MAX;
          1: return S_MIN;
          2: return sample_t'(0);
          3: return sample_t'(-1);
          default: return sample_t'(1);
        endcase
      end
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic frac_t pick_frac();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: return frac_t'(0);
        1: return F_FULL;
        2: return F_HALF;
        default: return frac_t'(1);
      endcase
    end
    return frac_t'($urandom());
  endfunction

  // stimulus
  initial begin
    int unsigned kind, mode, gap;
    int          base;
    rows_if.valid    = 1'b0;
    rows_if.sample_0 = '0;
    rows_if.sample_1 = '0;
    rows_if.sample_2 = '0;
    rows_if.sample_3 = '0;
    rows_if.frac_y   = '0;
    rows_if.frac_x   = '0;
    pix_if.ready     = 1'b0;

    // flat zero field, frac_x set on the leading rows must be ignored
    for (int i = 0; i < 3; i++) add_row(0, 0, 0, 0, 0, F_FULL, $urandom_range(0, MAX_IDLE), 0);
    add_row(0, 0, 0, 0, 0, 0, $urandom_range(0, MAX_IDLE), 0);
    // flat full scale, both polarities
    for (int i = 0; i < 4; i++)
      add_row(S_MAX, S_MAX, S_MAX, S_MAX, F_FULL, F_FULL, $urandom_range(0, MAX_IDLE), 0);
    for (int i = 0; i < 4; i++)
      add_row(S_MIN, S_MIN, S_MIN, S_MIN, 0, F_HALF, $urandom_range(0, MAX_IDLE), 0);
    // overshoot within the rows, clipped high and low at the output
    for (int i = 0; i < 4; i++)
      add_row(S_MIN, S_MAX, S_MAX, S_MIN, F_HALF, F_HALF, $urandom_range(0, MAX_IDLE), 0);
    for (int i = 0; i < 4; i++)
      add_row(S_MAX, S_MIN, S_MIN, S_MAX, F_HALF, F_HALF, $urandom_range(0, MAX_IDLE), 0);
    // overshoot across rows only
    add_row(S_MIN, S_MIN, S_MIN, S_MIN, 8'd1, 8'd7, 0, 0);
    add_row(S_MAX, S_MAX, S_MAX, S_MAX, F_FULL, 8'd9, 0, 0);
    add_row(S_MAX, S_MAX, S_MAX, S_MAX, 8'd1, 8'd3, 0, 0);
    add_row(S_MIN, S_MIN, S_MIN, S_MIN, F_FULL, F_HALF, 0, 0);

    for (int g = 0; g < RAND_GROUPS; g++) begin
      mode = (g / 16) % 3;
      kind = $urandom_range(0, 5);
      kind = (kind < 3) ? 2 : (kind < 5) ? 0 : 1;
      base = $signed($urandom_range(0, 32000)) - 16000;
      for (int r = 0; r < 4; r++) begin
        gap = (mode == 0) ? 0 : (mode == 1) ? $urandom_range(0, MAX_IDLE) : $urandom_range(0, 3);
        add_row(pick_sample(kind, base), pick_sample(kind, base), pick_sample(kind, base),
                pick_sample(kind, base), pick_frac(), pick_frac(), gap,
                r == 0 && (g == 0 || g == RAND_GROUPS / 2));
      end
    end
    total_rows = row_q.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (rows_sent != total_rows) @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // row driver
  always @(negedge clk_i) begin
    if (rst_ni && !(rows_if.valid && !row_taken)) begin
      if (!staged && row_q.size() != 0) begin
        cur       = row_q.pop_front();
        staged    = 1'b1;
        wait_left = cur.gap;
      end
      if (staged && wait_left == 0 && !(cur.drain && pixel_q.size() != 0)) begin
        rows_if.sample_0 <= cur.smp[0];
        rows_if.sample_1 <= cur.smp[1];
        rows_if.sample_2 <= cur.smp[2];
        rows_if.sample_3 <= cur.smp[3];
        rows_if.frac_y   <= cur.fy;
        rows_if.frac_x   <= cur.fx;
        rows_if.valid    <= 1'b1;
        staged = 1'b0;
      end else begin
        rows_if.valid <= 1'b0;
        if (staged && wait_left != 0) wait_left--;
      end
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pix_taken) begin
        stall_left = ((results_seen / 40) % 3 == 0) ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        pix_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted rows, check accepted results
  always @(posedge clk_i) begin
    pixel_t want;
    row_taken <= rst_ni && rows_if.valid && rows_if.ready;
    pix_taken <= rst_ni && pix_if.valid && pix_if.ready;
    if (rst_ni && rows_if.valid && rows_if.ready) begin
      predict_pixel(rows_if.sample_0, rows_if.sample_1, rows_if.sample_2, rows_if.sample_3,
                    rows_if.frac_y, rows_if.frac_x);
      rows_sent++;
    end
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      results_seen++;
      if (pixel_q.size() == 0) begin
        $error("unexpected transaction: value %0d saturated %0b", pix_if.value,
               pix_if.saturated);
        faults++;
      end else begin
        want = pixel_q.pop_front();
        if (pix_if.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, pix_if.value);
          faults++;
        end
        if (pix_if.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, pix_if.saturated);
          faults++;
        end
      end
    end
  end

endmodule

// ----- sim.f -----
design/bci_pkg.sv
design/bci_if.sv
design/bci_cubic.sv
design/bci_front.sv
design/bci_back.sv
design/bicubic_interpolator_unit.sv
tb/bicubic_interpolator_unit_test.sv
